FILE: hdl/bmpc_pkg.sv
// ----------------------------------------------------------------------------
// bmpc_pkg
// shared types, constants and helper functions of the bitmap store
// ----------------------------------------------------------------------------
package bmpc_pkg;

  localparam int MAX_BITS_DEF = 4096;
  localparam int WORD_W       = 64;
  localparam int LEN_W        = 13;  // vector length register
  localparam int CNT_W        = 13;  // ones count
  localparam int IDX_W        = 12;  // bit index field
  localparam int OP_W         = 3;
  localparam int IN_W         = 16;  // opcode, bit_index, fill_value
  localparam int OUT_W        = 24;  // 17 result bits padded to whole bytes

  localparam logic [OP_W-1:0] OP_TEST   = 3'd0;
  localparam logic [OP_W-1:0] OP_SET    = 3'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd2;
  localparam logic [OP_W-1:0] OP_TOGGLE = 3'd3;
  localparam logic [OP_W-1:0] OP_FILL   = 3'd4;

  // sweep unit status toward the top level
  typedef struct packed {
    logic busy;
    logic clearing;
    logic rd_en;
    logic wr_en;
    logic done;
  } sweep_status_t;

  // ones for the bits of word word_idx that lie below len
  function automatic logic [WORD_W-1:0] word_mask(input logic [31:0] word_idx,
                                                  input logic [31:0] len);
    logic [31:0] base;
    logic [31:0] rem;
    base = word_idx << 6;
    rem  = len - base;
    if (len <= base) begin
      return '0;
    end else if (rem >= 32'd64) begin
      return '1;
    end else begin
      return ~({WORD_W{1'b1}} << rem[5:0]);
    end
  endfunction

  // population count, per byte then summed
  function automatic logic [6:0] pop64(input logic [WORD_W-1:0] w);
    logic [3:0] bc [8];
    logic [6:0] s;
    s = '0;
    for (int b = 0; b < 8; b++) begin
      bc[b] = '0;
      for (int k = 0; k < 8; k++) begin
        bc[b] = bc[b] + 4'(w[b*8+k]);
      end
    end
    for (int b = 0; b < 8; b++) begin
      s = s + 7'(bc[b]);
    end
    return s;
  endfunction

endpackage

FILE: hdl/bmpc_sweep.sv
// ----------------------------------------------------------------------------
// bmpc_sweep
// walks every word of the store: clear after reset, pattern fill, or
// trim beyond the length with a recount of the ones
// ----------------------------------------------------------------------------
module bmpc_sweep #(
  parameter int WORDS  = bmpc_pkg::MAX_BITS_DEF / bmpc_pkg::WORD_W,
  parameter int ADDR_W = 6
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        start_trim,
  input  logic                        fill_bit,
  input  logic [bmpc_pkg::LEN_W-1:0]  len,
  input  logic [bmpc_pkg::WORD_W-1:0] rd_data,
  output bmpc_pkg::sweep_status_t     st,
  output logic [ADDR_W-1:0]           rd_addr,
  output logic [ADDR_W-1:0]           wr_addr,
  output logic [bmpc_pkg::WORD_W-1:0] wr_data,
  output logic [bmpc_pkg::CNT_W-1:0]  total
);

  logic                        busy;
  logic                        clr;
  logic                        trim;
  logic                        pat_one;
  logic                        rd_act;
  logic                        wr_pend;
  logic [ADDR_W-1:0]           idx;
  logic [ADDR_W-1:0]           wr_idx;
  logic [bmpc_pkg::CNT_W-1:0]  acc;
  logic [bmpc_pkg::WORD_W-1:0] masked;
  logic [6:0]                  masked_pop;
  logic                        last;

  assign last       = (idx == ADDR_W'(WORDS - 1));
  assign masked     = rd_data & bmpc_pkg::word_mask(32'(wr_idx), 32'(len));
  assign masked_pop = bmpc_pkg::pop64(masked);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr     <= 1'b1;
      trim    <= 1'b0;
      pat_one <= 1'b0;
      rd_act  <= 1'b0;
      wr_pend <= 1'b0;
      idx     <= '0;
      acc     <= '0;
    end else if (start) begin
      busy    <= 1'b1;
      clr     <= 1'b0;
      trim    <= start_trim;
      pat_one <= fill_bit;
      rd_act  <= start_trim;
      wr_pend <= 1'b0;
      idx     <= '0;
      acc     <= '0;
    end else if (busy) begin
      if (!trim) begin
        if (last) begin
          busy <= 1'b0;
          clr  <= 1'b0;
        end else begin
          idx <= idx + ADDR_W'(1);
        end
      end else begin
        // read stage
        if (rd_act) begin
          rd_act <= !last;
          if (!last) begin
            idx <= idx + ADDR_W'(1);
          end
        end
        wr_pend <= rd_act;
        wr_idx  <= idx;
        // mask, write back and count stage
        if (wr_pend) begin
          acc <= acc + bmpc_pkg::CNT_W'(masked_pop);
          if (!rd_act) begin
            busy <= 1'b0;
          end
        end
      end
    end
  end

  always_comb begin
    st.busy     = busy;
    st.clearing = busy && clr;
    st.rd_en    = busy && trim && rd_act;
    rd_addr     = idx;
    if (trim) begin
      st.wr_en = busy && wr_pend;
      wr_addr  = wr_idx;
      wr_data  = masked;
      st.done  = busy && wr_pend && !rd_act;
      total    = acc + bmpc_pkg::CNT_W'(masked_pop);
    end else begin
      st.wr_en = busy;
      wr_addr  = idx;
      wr_data  = pat_one ? bmpc_pkg::word_mask(32'(idx), 32'(len)) : '0;
      st.done  = busy && last;
      total    = pat_one ? bmpc_pkg::CNT_W'(len) : '0;
    end
  end

endmodule

FILE: hdl/bitmap_store_with_population_count.sv
// ----------------------------------------------------------------------------
// bitmap_store_with_population_count
// bit vector store with test, set, clear, toggle, fill and a running count
// ----------------------------------------------------------------------------
// The vector sits in one 64-bit-wide memory of (MAX_BITS+63)/64 words with
// a registered read. Test, set, clear and toggle take one word each and run
// at one word per cycle while the output and the sweep unit do not stall
// them: the word is read when the input word is taken, then modified,
// written back and loaded into the result register in the execute stage
// once the output is free, with the last written word forwarded when two
// operations in a row hit the same memory word. A fill walks the memory
// one word per cycle and holds the input until it is through. After reset
// a clearing pass zeros the memory; no input word is taken during it, while
// a length write is taken as usual. A length write trims every bit at or
// beyond the new length and recounts, one word per cycle, while input and
// further length writes wait. A length write offered in the same cycle as
// an input word goes first and the input word waits. A length above
// MAX_BITS acts as MAX_BITS. One result word per input word; a result
// waiting at the output does not stop the next input word from entering.
module bitmap_store_with_population_count #(
  parameter int MAX_BITS = bmpc_pkg::MAX_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // input stream
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [bmpc_pkg::IN_W-1:0]   s_tdata,   // opcode, bit_index, fill_value
  // result stream
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [bmpc_pkg::OUT_W-1:0]  m_tdata,   // old_bit, bit_changed,
                                                 // range_error, ones_count,
                                                 // any_set, zero pad
  // length register write
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [bmpc_pkg::LEN_W-1:0]  cfg_data
);

  localparam int WORDS  = (MAX_BITS + bmpc_pkg::WORD_W - 1) / bmpc_pkg::WORD_W;
  localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;

  // ---- storage -------------------------------------------------------------
  logic [bmpc_pkg::WORD_W-1:0] mem [WORDS];
  logic [bmpc_pkg::WORD_W-1:0] rd_data;
  logic                        mem_rd_en;
  logic [ADDR_W-1:0]           mem_rd_addr;
  logic                        mem_wr_en;
  logic [ADDR_W-1:0]           mem_wr_addr;
  logic [bmpc_pkg::WORD_W-1:0] mem_wr_data;

  // ---- control registers ---------------------------------------------------
  logic [bmpc_pkg::LEN_W-1:0]  len_used;
  logic [bmpc_pkg::CNT_W-1:0]  ones_total;

  // ---- execute stage (word read is in flight or done) ----------------------
  logic                        s1_valid;
  logic [bmpc_pkg::OP_W-1:0]   s1_op;
  logic [bmpc_pkg::IDX_W-1:0]  s1_idx;
  logic                        s1_fill;
  logic                        s1_fwd;
  logic [bmpc_pkg::WORD_W-1:0] s1_fwd_word;
  logic                        fill_started;

  // ---- sweep unit ----------------------------------------------------------
  bmpc_pkg::sweep_status_t     swp_st;
  logic                        swp_start;
  logic                        swp_trim;
  logic [ADDR_W-1:0]           swp_rd_addr;
  logic [ADDR_W-1:0]           swp_wr_addr;
  logic [bmpc_pkg::WORD_W-1:0] swp_wr_data;
  logic [bmpc_pkg::CNT_W-1:0]  swp_total;

  // ---- decode of the incoming word ----------------------------------------
  logic [bmpc_pkg::OP_W-1:0]   in_op;
  logic [bmpc_pkg::IDX_W-1:0]  in_idx;
  logic                        in_fill;
  logic [ADDR_W-1:0]           in_waddr;
  logic                        s_accept;
  logic                        cfg_accept;
  logic [bmpc_pkg::LEN_W-1:0]  cfg_len;

  // ---- execute stage logic ------------------------------------------------
  logic [bmpc_pkg::WORD_W-1:0] b_word;
  logic [bmpc_pkg::WORD_W-1:0] b_new_word;
  logic [ADDR_W-1:0]           b_waddr;
  logic                        b_old;
  logic                        b_nb;
  logic                        b_is_bit;
  logic                        b_err;
  logic                        b_chg;
  logic                        fill_go;
  logic                        out_free;
  logic                        s1_adv;
  logic                        item_wr;
  logic [bmpc_pkg::CNT_W-1:0]  ones_next;

  // ---- result register -----------------------------------------------------
  logic                        m_valid;
  logic                        r_old;
  logic                        r_chg;
  logic                        r_err;
  logic [bmpc_pkg::CNT_W-1:0]  r_count;

  assign in_op    = s_tdata[2:0];
  assign in_idx   = s_tdata[14:3];
  assign in_fill  = s_tdata[15];
  assign in_waddr = ADDR_W'(in_idx >> 6);

  // a length above the built-in maximum acts as the maximum
  assign cfg_len = (32'(cfg_data) > 32'(MAX_BITS)) ? bmpc_pkg::LEN_W'(MAX_BITS)
                                                   : cfg_data;

  // length writes are taken while nothing is in flight; during the clearing
  // pass the store is all zero anyway, so no trim is needed then
  assign cfg_ready  = !rst && !s1_valid && (!swp_st.busy || swp_st.clearing);
  assign cfg_accept = cfg_valid && cfg_ready;

  // ---- execute stage -------------------------------------------------------
  always_comb begin
    b_word   = s1_fwd ? s1_fwd_word : rd_data;
    b_old    = b_word[s1_idx[5:0]];
    b_waddr  = ADDR_W'(s1_idx >> 6);
    b_is_bit = (s1_op == bmpc_pkg::OP_TEST) || (s1_op == bmpc_pkg::OP_SET) ||
               (s1_op == bmpc_pkg::OP_CLEAR) || (s1_op == bmpc_pkg::OP_TOGGLE);
    if (b_is_bit) begin
      b_err = (len_used == '0) || ({1'b0, s1_idx} >= len_used);
    end else begin
      b_err = (s1_op == bmpc_pkg::OP_FILL) && (len_used == '0);
    end
    case (s1_op)
      bmpc_pkg::OP_SET:    b_nb = 1'b1;
      bmpc_pkg::OP_CLEAR:  b_nb = 1'b0;
      bmpc_pkg::OP_TOGGLE: b_nb = !b_old;
      default:             b_nb = b_old;
    endcase
    b_chg      = b_is_bit && !b_err && (b_nb != b_old);
    b_new_word = b_word;
    b_new_word[s1_idx[5:0]] = b_nb;
    if (b_chg) begin
      ones_next = b_nb ? ones_total + bmpc_pkg::CNT_W'(1)
                       : ones_total - bmpc_pkg::CNT_W'(1);
    end else begin
      ones_next = ones_total;
    end
  end

  // a fill with a nonzero length hands the memory to the sweep unit and
  // reports once the sweep is through
  assign fill_go  = s1_valid && (s1_op == bmpc_pkg::OP_FILL) && (len_used != '0);
  assign out_free = !m_valid || m_tready;
  assign s1_adv   = s1_valid && out_free && (!fill_go || (fill_started && !swp_st.busy));
  assign item_wr  = s1_adv && b_chg;

  // a length write taken in this cycle starts a trim if not clearing; input waits
  assign s_tready = !swp_st.busy && !cfg_accept && (!s1_valid || s1_adv);
  assign s_accept = s_tvalid && s_tready;

  assign swp_start = (fill_go && !fill_started) || (cfg_accept && !swp_st.busy);
  assign swp_trim  = !fill_go;

  bmpc_sweep #(
    .WORDS  (WORDS),
    .ADDR_W (ADDR_W)
  ) u_sweep (
    .clk        (clk),
    .rst        (rst),
    .start      (swp_start),
    .start_trim (swp_trim),
    .fill_bit   (s1_fill),
    .len        (len_used),
    .rd_data    (rd_data),
    .st         (swp_st),
    .rd_addr    (swp_rd_addr),
    .wr_addr    (swp_wr_addr),
    .wr_data    (swp_wr_data),
    .total      (swp_total)
  );

  // ---- memory port selection -----------------------------------------------
  always_comb begin
    if (swp_st.busy) begin
      mem_rd_en   = swp_st.rd_en;
      mem_rd_addr = swp_rd_addr;
      mem_wr_en   = swp_st.wr_en;
      mem_wr_addr = swp_wr_addr;
      mem_wr_data = swp_wr_data;
    end else begin
      mem_rd_en   = s_accept;
      mem_rd_addr = in_waddr;
      mem_wr_en   = item_wr;
      mem_wr_addr = b_waddr;
      mem_wr_data = b_new_word;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_wr_en) begin
      mem[mem_wr_addr] <= mem_wr_data;
    end
    if (mem_rd_en) begin
      rd_data <= mem[mem_rd_addr];
    end
  end

  // ---- control state -------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      len_used     <= '0;
      ones_total   <= '0;
      s1_valid     <= 1'b0;
      fill_started <= 1'b0;
      m_valid      <= 1'b0;
    end else begin
      if (cfg_accept) begin
        len_used <= cfg_len;
      end
      if (swp_st.done) begin
        ones_total <= swp_total;
      end else if (s1_adv) begin
        ones_total <= ones_next;
      end
      if (fill_go && !fill_started) begin
        fill_started <= 1'b1;
      end else if (s1_adv) begin
        fill_started <= 1'b0;
      end
      if (s_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        m_valid <= 1'b1;
      end else if (m_tready) begin
        m_valid <= 1'b0;
      end
    end
  end

  // ---- payload registers ---------------------------------------------------
  always_ff @(posedge clk) begin
    if (s_accept) begin
      s1_op       <= in_op;
      s1_idx      <= in_idx;
      s1_fill     <= in_fill;
      // same word written back in this cycle: memory returns the old word
      s1_fwd      <= item_wr && (b_waddr == in_waddr);
      s1_fwd_word <= b_new_word;
    end
    if (s1_adv) begin
      r_old   <= b_is_bit && !b_err && b_old;
      r_chg   <= b_chg;
      r_err   <= b_err;
      r_count <= ones_next;
    end
  end

  assign m_tvalid = m_valid;
  assign m_tdata  = {7'd0, (r_count != '0), r_count, r_err, r_chg, r_old};

`ifndef SYNTHESIS
  // no input word enters while the sweep owns the memory
  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (rst)
    s_accept |-> !swp_st.busy)
    else $error("input word taken during a sweep");

  // item write-back and sweep never compete for the write port
  a_single_writer: assert property (@(posedge clk) disable iff (rst)
    !(swp_st.wr_en && item_wr))
    else $error("item and sweep write in the same cycle");

  // the count never exceeds the bits in use once the store is settled
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    !swp_st.busy |-> (ones_total <= len_used))
    else $error("ones count above vector length");

  // a reset always starts the clearing pass
  a_clear_after_reset: assert property (@(posedge clk)
    $past(rst) && !rst |-> swp_st.clearing)
    else $error("no clearing pass after reset");

  // a changed bit moves the count by exactly one
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    item_wr |=> (ones_total == $past(ones_next)))
    else $error("count not updated by a bit change");
`endif

endmodule

FILE: dv/bitmap_store_with_population_count_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bitmap_store_with_population_count_check
// watches input, result and length channels, keeps a shadow copy of the bit
// vector and compares every result word field by field
// ----------------------------------------------------------------------------
module bitmap_store_with_population_count_check (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  input  logic                        s_tready,
  input  logic [bmpc_pkg::IN_W-1:0]   s_tdata,   // opcode, bit_index, fill_value
  input  logic                        m_tvalid,
  input  logic                        m_tready,
  input  logic [bmpc_pkg::OUT_W-1:0]  m_tdata,   // old_bit, bit_changed,
                                                 // range_error, ones_count,
                                                 // any_set, zero pad
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [bmpc_pkg::LEN_W-1:0]  cfg_data,
  output int                          fail_count,
  output int                          pending
);
  import bmpc_pkg::*;

  localparam int WORDS      = (MAX_BITS_DEF + 63) / 64;
  localparam int SHOW_LIMIT = 40;

  // result word, lowest field last
  typedef struct packed {
    logic             any_set;
    logic [CNT_W-1:0] ones_count;
    logic             range_error;
    logic             bit_changed;
    logic             old_bit;
  } bit_report_t;

  logic [WORD_W-1:0] shadow_bits [WORDS];
  int unsigned       shadow_ones;
  int unsigned       shadow_len;
  bit_report_t       awaited_reports [$];

  // zero every bit at or above len and recount
  function automatic void trim_beyond(input int unsigned len);
    int unsigned       base;
    logic [WORD_W-1:0] keep;
    shadow_ones = 0;
    for (int w = 0; w < WORDS; w++) begin
      base = w * WORD_W;
      if (base >= len) begin
        keep = '0;
      end else if (len - base >= WORD_W) begin
        keep = '1;
      end else begin
        keep = (64'd1 << (len - base)) - 64'd1;
      end
      shadow_bits[w] &= keep;
      shadow_ones += $countones(shadow_bits[w]);
    end
  endfunction

  function automatic bit_report_t predict_bit_op(input logic [OP_W-1:0]  op,
                                                 input logic [IDX_W-1:0] idx,
                                                 input logic             fill);
    bit_report_t r;
    int unsigned w;
    logic        was;
    logic        now_bit;
    r = '0;
    case (op)
      OP_TEST, OP_SET, OP_CLEAR, OP_TOGGLE: begin
        if (shadow_len == 0 || idx >= shadow_len) begin
          r.range_error = 1'b1;
        end else begin
          w   = idx >> 6;
          was = shadow_bits[w][idx[5:0]];
          case (op)
            OP_SET:    now_bit = 1'b1;
            OP_CLEAR:  now_bit = 1'b0;
            OP_TOGGLE: now_bit = ~was;
            default:   now_bit = was;
          endcase
          if (now_bit != was) begin
            shadow_bits[w][idx[5:0]] = now_bit;
            if (now_bit) begin
              shadow_ones++;
            end else begin
              shadow_ones--;
            end
            r.bit_changed = 1'b1;
          end
          r.old_bit = was;
        end
      end
      OP_FILL: begin
        if (shadow_len == 0) begin
          r.range_error = 1'b1;
        end else begin
          for (int k = 0; k < WORDS; k++) begin
            shadow_bits[k] = {WORD_W{fill}};
          end
          trim_beyond(shadow_len);
        end
      end
      default: ;  // unused opcodes leave the store alone
    endcase
    r.ones_count = CNT_W'(shadow_ones);
    r.any_set    = (shadow_ones != 0);
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      fail_count++;
      if (fail_count <= SHOW_LIMIT) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    end
  endfunction

  always @(posedge clk) begin : watch
    bit_report_t got;
    bit_report_t want;
    if (rst) begin
      for (int k = 0; k < WORDS; k++) begin
        shadow_bits[k] = '0;
      end
      shadow_ones = 0;
      shadow_len  = 0;
      fail_count  = 0;
      awaited_reports.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        shadow_len = (cfg_data > MAX_BITS_DEF) ? MAX_BITS_DEF : cfg_data;
        trim_beyond(shadow_len);
      end
      // results first, a word entering this cycle cannot leave in it
      if (m_tvalid && m_tready) begin
        got = bit_report_t'(m_tdata[$bits(bit_report_t)-1:0]);
        if (awaited_reports.size() == 0) begin
          fail_count++;
          if (fail_count <= SHOW_LIMIT) begin
            $display("%0t: result word with nothing expected, expected none, actual %h",
                     $time, m_tdata);
          end
        end else begin
          want = awaited_reports.pop_front();
          check_field("old_bit", want.old_bit, got.old_bit);
          check_field("bit_changed", want.bit_changed, got.bit_changed);
          check_field("range_error", want.range_error, got.range_error);
          check_field("ones_count", want.ones_count, got.ones_count);
          check_field("any_set", want.any_set, got.any_set);
        end
      end
      if (s_tvalid && s_tready) begin
        awaited_reports.push_back(predict_bit_op(s_tdata[OP_W-1:0],
                                                 s_tdata[OP_W+IDX_W-1:OP_W],
                                                 s_tdata[OP_W+IDX_W]));
      end
    end
    pending = awaited_reports.size();
  end

endmodule

FILE: dv/bitmap_store_with_population_count_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bitmap_store_with_population_count_test
// directed and random bit operations over a range of vector lengths, with
// bursty input, stalling output and one long output hold-off
// ----------------------------------------------------------------------------
module bitmap_store_with_population_count_test;
  import bmpc_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;  // quiet cycles before giving up
  localparam int LONG_HOLD      = 400;   // output hold-off, fills the block
  localparam int SETTLE         = 8;     // cycles after the last result word
  localparam int PHASES         = 12;
  localparam int PHASE_ITEMS    = 135;

  // opcodes the block does not define, the store must stay untouched
  localparam logic [OP_W-1:0] OP_RSVD_A = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_B = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_C = 3'd7;

  logic                clk;
  logic                rst       = 1'b1;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [IN_W-1:0]     s_tdata   = '0;  // opcode, bit_index, fill_value
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [OUT_W-1:0]    m_tdata;         // old_bit, bit_changed, range_error,
                                        // ones_count, any_set, zero pad
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [LEN_W-1:0]    cfg_data  = '0;

  int                  fail_count;
  int                  pending;

  // sender state
  int                  burst_left   = 0;
  bit                  gapless      = 1'b0;
  int unsigned         eff_len      = 0;     // length in use, clamped
  bit                  hold_request = 1'b0;

  logic [OP_W-1:0]     bit_ops   [4] = '{OP_TEST, OP_SET, OP_CLEAR, OP_TOGGLE};
  logic [OP_W-1:0]     rsvd_ops  [3] = '{OP_RSVD_A, OP_RSVD_B, OP_RSVD_C};
  // lengths per random phase: extremes, word edges, over-range values
  logic [LEN_W-1:0]    phase_len [PHASES] = '{13'd4096, 13'd1, 13'd64, 13'd8191,
                                              13'd65, 13'd37, 13'd4095, 13'd0,
                                              13'd5000, 13'd128, 13'd4096, 13'd0};

  bitmap_store_with_population_count dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  bitmap_store_with_population_count_check report_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // offer one input word, starts and ends at a falling edge
  task automatic send_op(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                         input logic fill);
    int gap;
    if (!gapless && burst_left == 0) begin
      // end of a burst, drop valid for a while
      burst_left = $urandom_range(1, 24);
      gap        = $urandom_range(1, 8);
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    if (burst_left > 0) begin
      burst_left--;
    end
    s_tdata  <= {fill, idx, op};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // length write, only once every result word is back
  task automatic write_length(input logic [LEN_W-1:0] len);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_data  <= len;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    eff_len = (len > MAX_BITS_DEF) ? MAX_BITS_DEF : len;
  endtask

  // mostly in-range bit ops, some errors, fills and unused opcodes
  task automatic random_item();
    int              r;
    int              pick;
    logic [OP_W-1:0] op;
    logic [IDX_W-1:0] idx;
    logic            fill;
    r    = $urandom_range(0, 99);
    fill = 1'($urandom_range(0, 1));
    if (r < 3) begin
      op = OP_FILL;
    end else if (r < 6) begin
      op = rsvd_ops[$urandom_range(0, 2)];
    end else begin
      op = bit_ops[$urandom_range(0, 3)];
    end
    pick = $urandom_range(0, 99);
    if (eff_len == 0 || pick < 8) begin
      idx = IDX_W'($urandom);
    end else if (pick < 14) begin
      // around the top of the vector
      idx = IDX_W'(eff_len - 1 + $urandom_range(0, 2));
    end else begin
      idx = IDX_W'($urandom_range(0, eff_len - 1));
    end
    send_op(op, idx, fill);
  endtask

  // result side: stall patterns that change now and then, plus one long hold
  initial begin : receiver
    int mode;
    int mode_left;
    int hold_left;
    int tick;
    bit hold_taken;
    mode       = 0;
    mode_left  = 0;
    hold_left  = 0;
    tick       = 0;
    hold_taken = 1'b0;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      if (hold_request && !hold_taken) begin
        hold_left  = LONG_HOLD;
        hold_taken = 1'b1;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(32, 256);
      end
      mode_left--;
      tick++;
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (mode)
          0:       m_tready <= 1'b1;                          // never stalls
          1:       m_tready <= 1'($urandom_range(0, 1));
          2:       m_tready <= (tick % 4 == 0);               // one in four
          default: m_tready <= ($urandom_range(0, 9) != 0);
        endcase
      end
      @(negedge clk);
    end
  end

  // nothing accepted for too long means a hang
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("[bitmap_store_with_population_count] ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed, no gaps so neighbors hit the forwarding path
    gapless = 1'b1;
    // length zero straight out of reset, everything errors
    send_op(OP_TEST, 12'd0, 1'b0);
    send_op(OP_FILL, 12'd0, 1'b1);
    send_op(OP_SET, 12'd5, 1'b0);

    write_length(13'd70);
    send_op(OP_SET, 12'd0, 1'b0);
    send_op(OP_SET, 12'd69, 1'b0);
    send_op(OP_TEST, 12'd69, 1'b0);
    send_op(OP_TOGGLE, 12'd69, 1'b0);
    send_op(OP_TOGGLE, 12'd69, 1'b0);
    send_op(OP_SET, 12'd10, 1'b0);         // same word twice in a row
    send_op(OP_TOGGLE, 12'd10, 1'b0);
    send_op(OP_SET, 12'd63, 1'b0);         // across a word boundary
    send_op(OP_SET, 12'd64, 1'b0);
    send_op(OP_TEST, 12'd70, 1'b0);        // first index past the end
    send_op(OP_SET, 12'd4095, 1'b0);       // top index, out of range
    send_op(OP_CLEAR, 12'd1, 1'b0);        // clear of a bit already zero
    send_op(OP_FILL, 12'hABC, 1'b1);       // index ignored on fill
    send_op(OP_TEST, 12'd5, 1'b0);
    send_op(OP_RSVD_A, 12'd5, 1'b1);
    send_op(OP_RSVD_B, 12'd0, 1'b0);
    send_op(OP_RSVD_C, 12'hFFF, 1'b1);
    send_op(OP_CLEAR, 12'd0, 1'b0);
    send_op(OP_FILL, 12'd0, 1'b0);
    send_op(OP_FILL, 12'd0, 1'b1);
    // shrink trims to three ones, growing back brings in zeros
    write_length(13'd3);
    send_op(OP_TEST, 12'd2, 1'b0);
    write_length(13'd100);
    send_op(OP_TEST, 12'd50, 1'b0);

    // random phases, each opens with a fill to give the store some content
    gapless = 1'b0;
    phase_len[PHASES-1] = LEN_W'($urandom_range(2, 300));
    for (int p = 0; p < PHASES; p++) begin
      write_length(phase_len[p]);
      gapless = ($urandom_range(0, 3) == 0);
      send_op(OP_FILL, IDX_W'($urandom), 1'($urandom_range(0, 1)));
      for (int n = 1; n < PHASE_ITEMS; n++) begin
        if (p == 2 && n == 10) begin
          hold_request = 1'b1;  // sender keeps going against a stalled output
        end
        random_item();
      end
    end

    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (fail_count == 0) begin
      $display("[bitmap_store_with_population_count] OK");
    end else begin
      $display("[bitmap_store_with_population_count] ERROR");
    end
    $finish;
  end

endmodule
